>>> rtl/grid_line_of_sight_check_core_assert.svh
// Assertion macros for the grid line-of-sight check core.
// Included by the top level; the checks compile away when SYNTH is defined.
`ifndef GRID_LINE_OF_SIGHT_CHECK_CORE_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_CHECK_CORE_ASSERT_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define GLOS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glos: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define GLOS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glos: next-cycle check failed");
`else
`define GLOS_ASSERT_NOW(label, clk, rst, ante, cons)
`define GLOS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/glos_pkg.sv
// Shared constants and types of the grid line-of-sight check core.
// No dependencies; every other RTL file but the assertion header refers to this package.
`default_nettype none

package glos_pkg;

   // Field widths fixed by the transaction format.
   localparam int COORD_W = 5;
   localparam int STEPS_W = 7;

   // Map geometry.
   localparam int MAP_TILES = 32;
   localparam int MAP_AW    = $clog2(MAP_TILES);
   localparam logic [COORD_W:0] MAP_LIMIT = (COORD_W + 1)'(MAP_TILES);

   // Sub-cell coordinates run at twice the tile resolution.
   localparam int SUB_W = COORD_W + 1;

   // Holds (1 + 2 * ix) * ny for the longest walk of the sub-cell grid.
   localparam int ACC_W = 13;

   // Reset value of the walk length limit.
   localparam logic [STEPS_W-1:0] MAX_STEPS_RESET = STEPS_W'(18);

   // Four sub-cell offsets are tried per query.
   localparam logic [1:0] LAST_WALK = 2'd3;

   // Command queue between the front and back ends.
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   // Opcode of an input transaction.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_QUERY,
      CMD_ZERO
   } cmd_kind_type;

   // One classified command; a and b are the written tile or observer/target.
   typedef struct packed {
      cmd_kind_type       kind;
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
      logic               open;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

>>> rtl/glos_channels.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on glos_pkg for field widths.
`default_nettype none

interface glos_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [glos_pkg::COORD_W-1:0] tile_x;
   logic [glos_pkg::COORD_W-1:0] tile_y;
   logic                         tile_open;
   logic [glos_pkg::COORD_W-1:0] observer_x;
   logic [glos_pkg::COORD_W-1:0] observer_y;
   logic [glos_pkg::COORD_W-1:0] target_x;
   logic [glos_pkg::COORD_W-1:0] target_y;
   logic                         target_present;

   modport source (
      output valid, opcode, tile_x, tile_y, tile_open,
      output observer_x, observer_y, target_x, target_y, target_present,
      input  ready
   );
   modport sink (
      input  valid, opcode, tile_x, tile_y, tile_open,
      input  observer_x, observer_y, target_x, target_y, target_present,
      output ready
   );
endinterface

interface glos_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

>>> rtl/glos_front.sv
// Front end: accepts request transactions and classifies them into commands.
// Depends on glos_pkg and the glos_req_if channel.
`default_nettype none

module glos_front (
   glos_req_if.sink              req_chan,
   input  glos_pkg::q_status_type q_stat,
   output logic                  q_push,
   output glos_pkg::cmd_type     q_wdata
);

   logic accept;
   logic wr_on_map;
   logic query_ok;

   // Accept whenever the queue has room.
   assign req_chan.ready = !q_stat.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Range checks of the tile coordinates.
   assign wr_on_map = ({1'b0, req_chan.tile_x} < glos_pkg::MAP_LIMIT) &&
                      ({1'b0, req_chan.tile_y} < glos_pkg::MAP_LIMIT);
   assign query_ok  = req_chan.target_present &&
                      ({1'b0, req_chan.observer_x} < glos_pkg::MAP_LIMIT) &&
                      ({1'b0, req_chan.observer_y} < glos_pkg::MAP_LIMIT) &&
                      ({1'b0, req_chan.target_x} < glos_pkg::MAP_LIMIT) &&
                      ({1'b0, req_chan.target_y} < glos_pkg::MAP_LIMIT);

   // Build the command; writes off the map are dropped here.
   always_comb begin
      q_wdata.open = req_chan.tile_open;
      if (req_chan.opcode == glos_pkg::OP_WRITE) begin
         q_wdata.kind = glos_pkg::CMD_WRITE;
         q_wdata.ax   = req_chan.tile_x;
         q_wdata.ay   = req_chan.tile_y;
         q_wdata.bx   = req_chan.tile_x;
         q_wdata.by   = req_chan.tile_y;
         q_push       = accept && wr_on_map;
      end else begin
         q_wdata.kind = query_ok ? glos_pkg::CMD_QUERY : glos_pkg::CMD_ZERO;
         q_wdata.ax   = req_chan.observer_x;
         q_wdata.ay   = req_chan.observer_y;
         q_wdata.bx   = req_chan.target_x;
         q_wdata.by   = req_chan.target_y;
         q_push       = accept;
      end
   end

endmodule

`default_nettype wire

>>> rtl/glos_fifo.sv
// Short command queue between the front and back ends.
// Depends on glos_pkg for the command type and depth.
`default_nettype none

module glos_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  glos_pkg::cmd_type      wdata,
   input  logic                   pop,
   output glos_pkg::cmd_type      rdata,
   output glos_pkg::q_status_type stat
);

   glos_pkg::cmd_type             entry_ff [glos_pkg::Q_DEPTH];
   logic [glos_pkg::Q_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [glos_pkg::Q_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [glos_pkg::Q_CW-1:0]     count_ff, count_in;

   assign stat.full  = (count_ff == glos_pkg::Q_CW'(glos_pkg::Q_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rdata      = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/glos_tile_map.sv
// Tile accessibility store: one memory row per map row, with row valid bits.
// Depends on glos_pkg for the map geometry.
`default_nettype none

module glos_tile_map (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [glos_pkg::MAP_AW-1:0] wr_x,
   input  logic [glos_pkg::MAP_AW-1:0] wr_y,
   input  logic                        wr_open,
   input  logic [glos_pkg::MAP_AW-1:0] rd_x,
   input  logic [glos_pkg::MAP_AW-1:0] rd_y,
   output logic                        rd_open
);

   logic [glos_pkg::MAP_TILES-1:0] row_mem [glos_pkg::MAP_TILES];
   logic [glos_pkg::MAP_TILES-1:0] row_valid_ff;
   logic [glos_pkg::MAP_TILES-1:0] rd_row_ff;
   logic                           rd_valid_ff;
   logic [glos_pkg::MAP_AW-1:0]    rd_x_ff;
   logic [glos_pkg::MAP_TILES-1:0] fresh_row;

   // A row never written reads as all blocked, so its first write replaces it.
   assign fresh_row = glos_pkg::MAP_TILES'(wr_open) << wr_x;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (row_valid_ff[wr_y]) begin
            row_mem[wr_y][wr_x] <= wr_open;
         end else begin
            row_mem[wr_y] <= fresh_row;
         end
      end
      rd_row_ff <= row_mem[rd_y];
      rd_x_ff   <= rd_x;
   end

   // Row valid bits are control state and clear at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_y] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_y];
      end
   end

   assign rd_open = rd_valid_ff && rd_row_ff[rd_x_ff];

endmodule

`default_nettype wire

>>> rtl/glos_walker.sv
// Back end: applies tile writes and walks the sub-cell grid for queries.
// Depends on glos_pkg, glos_rsp_if and glos_tile_map.
`default_nettype none

module glos_walker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [glos_pkg::STEPS_W-1:0]   csr_wr_data,
   input  glos_pkg::q_status_type         q_stat,
   input  glos_pkg::cmd_type              q_rdata,
   output logic                           q_pop,
   output logic                           rsp_load,
   glos_rsp_if.source                     rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_RESULT
   } state_type;

   state_type                      state_ff, state_in;
   logic [glos_pkg::STEPS_W-1:0]   max_steps_ff, max_steps_in;
   glos_pkg::cmd_type              cmd_ff, cmd_in;
   logic [1:0]                     walk_ff, walk_in;
   logic [glos_pkg::SUB_W-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic [glos_pkg::SUB_W-1:0]     nx_ff, nx_in, ny_ff, ny_in;
   logic [glos_pkg::SUB_W-1:0]     ix_ff, ix_in, iy_ff, iy_in;
   logic [glos_pkg::ACC_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic                           xup_ff, xup_in, yup_ff, yup_in;
   logic                           pend_ff, pend_in;
   logic                           vis_ff, vis_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_vis_ff, rsp_vis_in;

   logic                           map_wr_en;
   logic                           map_open;
   logic [glos_pkg::COORD_W-1:0]   dtx, dty;
   logic                           set_xup, set_yup;
   logic [glos_pkg::SUB_W-1:0]     set_nx, set_ny;
   logic [glos_pkg::STEPS_W-1:0]   set_len;
   logic                           more;
   logic                           h_step;
   logic                           walk_fail;

   glos_tile_map u_map (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (map_wr_en),
      .wr_x    (q_rdata.ax),
      .wr_y    (q_rdata.ay),
      .wr_open (q_rdata.open),
      .rd_x    (cx_in[glos_pkg::SUB_W-1:1]),
      .rd_y    (cy_in[glos_pkg::SUB_W-1:1]),
      .rd_open (map_open)
   );

   // Walk geometry; the sub-cell offset cancels in the distances.
   assign set_xup = cmd_ff.bx > cmd_ff.ax;
   assign set_yup = cmd_ff.by > cmd_ff.ay;
   assign dtx     = set_xup ? cmd_ff.bx - cmd_ff.ax : cmd_ff.ax - cmd_ff.bx;
   assign dty     = set_yup ? cmd_ff.by - cmd_ff.ay : cmd_ff.ay - cmd_ff.by;
   assign set_nx  = {dtx, 1'b0};
   assign set_ny  = {dty, 1'b0};
   assign set_len = glos_pkg::STEPS_W'(set_nx) + glos_pkg::STEPS_W'(set_ny);

   // Step choice: a tracks (1 + 2 * ix) * ny and b tracks (1 + 2 * iy) * nx.
   assign more   = (ix_ff < nx_ff) || (iy_ff < ny_ff);
   assign h_step = (a_ff <= b_ff);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.visible = rsp_vis_ff;

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      max_steps_in = csr_wr_en ? csr_wr_data : max_steps_ff;
      cmd_in       = cmd_ff;
      walk_in      = walk_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      ix_in        = ix_ff;
      iy_in        = iy_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      xup_in       = xup_ff;
      yup_in       = yup_ff;
      pend_in      = pend_ff;
      vis_in       = vis_ff;
      q_pop        = 1'b0;
      map_wr_en    = 1'b0;
      rsp_load     = 1'b0;
      walk_fail    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               case (q_rdata.kind)
                  glos_pkg::CMD_WRITE: begin
                     map_wr_en = 1'b1;
                  end
                  glos_pkg::CMD_QUERY: begin
                     cmd_in   = q_rdata;
                     walk_in  = '0;
                     state_in = ST_SETUP;
                  end
                  default: begin
                     vis_in   = 1'b0;
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end

         ST_SETUP: begin
            cx_in   = {cmd_ff.ax, walk_ff[0]};
            cy_in   = {cmd_ff.ay, walk_ff[1]};
            nx_in   = set_nx;
            ny_in   = set_ny;
            xup_in  = set_xup;
            yup_in  = set_yup;
            ix_in   = '0;
            iy_in   = '0;
            a_in    = glos_pkg::ACC_W'(set_ny);
            b_in    = glos_pkg::ACC_W'(set_nx);
            pend_in = 1'b0;
            if (set_len > max_steps_ff) begin
               walk_fail = 1'b1;
            end else if (set_len == '0) begin
               vis_in   = 1'b1;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_WALK;
            end
         end

         ST_WALK: begin
            if (pend_ff && !map_open) begin
               walk_fail = 1'b1;
            end else if (more) begin
               // Step into the next cell and read it; checked next cycle.
               pend_in = 1'b1;
               if (h_step) begin
                  cx_in = xup_ff ? cx_ff + 1'b1 : cx_ff - 1'b1;
                  ix_in = ix_ff + 1'b1;
                  a_in  = a_ff + glos_pkg::ACC_W'({ny_ff, 1'b0});
               end else begin
                  cy_in = yup_ff ? cy_ff + 1'b1 : cy_ff - 1'b1;
                  iy_in = iy_ff + 1'b1;
                  b_in  = b_ff + glos_pkg::ACC_W'({nx_ff, 1'b0});
               end
            end else begin
               vis_in   = 1'b1;
               state_in = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A failed walk moves on to the next offset or answers not visible.
      if (walk_fail) begin
         if (walk_ff == glos_pkg::LAST_WALK) begin
            vis_in   = 1'b0;
            state_in = ST_RESULT;
         end else begin
            walk_in  = walk_ff + 1'b1;
            state_in = ST_SETUP;
         end
      end
   end

   // Response output register.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_vis_in   = rsp_load ? vis_ff : rsp_vis_ff;

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      walk_ff    <= walk_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      ix_ff      <= ix_in;
      iy_ff      <= iy_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      xup_ff     <= xup_in;
      yup_ff     <= yup_in;
      vis_ff     <= vis_in;
      rsp_vis_ff <= rsp_vis_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_steps_ff <= glos_pkg::MAX_STEPS_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_steps_ff <= max_steps_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/grid_line_of_sight_check_core.sv
// Top level of the grid line-of-sight check core.
// Depends on glos_pkg, the channel interfaces, glos_front, glos_fifo, glos_walker.
//
//   Channel    Direction  Handshake          Carries
//   req_chan   in         valid / ready      tile write or visibility query
//   rsp_chan   out        valid / ready      visible flag, one per query
//   csr_*      in         write enable only  max_path_steps (7 bits)
//
// A tile write is applied when the back end pops it. A query passes through the setup state
// for each offset tried and, when the walk fits the limit and has steps, through the walk
// state with one map row read per step, then the result state. A four-entry command queue
// lets the front accept while the back walks, and the response register lets the next item
// start while a result waits. Reset is synchronous; map rows carry valid bits, so every
// tile reads blocked after reset with no clearing pass.
`default_nettype none
`include "grid_line_of_sight_check_core_assert.svh"

module grid_line_of_sight_check_core (
   input  logic                         clock,
   input  logic                         reset,
   glos_req_if.sink                     req_chan,
   glos_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [glos_pkg::STEPS_W-1:0] csr_wr_data
);

   glos_pkg::q_status_type q_stat;
   glos_pkg::cmd_type      q_wdata;
   glos_pkg::cmd_type      q_rdata;
   logic                   q_push;
   logic                   q_pop;
   logic                   rsp_load;

   // Classification of incoming transactions.
   glos_front u_front (
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_wdata  (q_wdata)
   );

   // Command queue.
   glos_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   // Map store and walk sequencer.
   glos_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_stat      (q_stat),
      .q_rdata     (q_rdata),
      .q_pop       (q_pop),
      .rsp_load    (rsp_load),
      .rsp_chan    (rsp_chan)
   );

   // Queue is never pushed when full nor popped when empty.
   `GLOS_ASSERT_NOW(a_push_room, clock, reset, q_push, !q_stat.full)
   `GLOS_ASSERT_NOW(a_pop_data, clock, reset, q_pop, !q_stat.empty)
   // A result is loaded only into a free or draining response register.
   `GLOS_ASSERT_NOW(a_load_free, clock, reset, rsp_load, !rsp_chan.valid || rsp_chan.ready)
   `GLOS_ASSERT_NEXT(a_load_shown, clock, reset, rsp_load, rsp_chan.valid)

endmodule

`default_nettype wire

>>> bench/grid_line_of_sight_check_core_test.sv
// Self-checking testbench for grid_line_of_sight_check_core: a directed table, then bursts
// of tile writes and queries under several walk limits and idling patterns.
// Depends on glos_pkg and the glos_req_if / glos_rsp_if channel interfaces.
module grid_line_of_sight_check_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import glos_pkg::*;

   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   // One request transaction, field by field.
   typedef struct packed {
      logic               opcode;
      logic [COORD_W-1:0] tile_x;
      logic [COORD_W-1:0] tile_y;
      logic               tile_open;
      logic [COORD_W-1:0] observer_x;
      logic [COORD_W-1:0] observer_y;
      logic [COORD_W-1:0] target_x;
      logic [COORD_W-1:0] target_y;
      logic               target_present;
   } los_item_type;

   localparam int ITEM_W = $bits(los_item_type);

   // A directed row either carries its answer or leaves it to the predictor.
   localparam logic KNOWN     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   typedef struct packed {
      los_item_type item;
      logic         known;
      logic         visible;
   } sight_row_type;

   // One random phase: walk limit, idling odds in percent, transaction count.
   typedef struct packed {
      logic [STEPS_W-1:0] max_steps;
      logic [6:0]         sender_idle;
      logic [6:0]         receiver_stall;
      logic [9:0]         items;
   } phase_type;

   localparam int DIRECTED_COUNT = 25;
   // Columns: opcode, tile x/y, open, observer x/y, target x/y, present; known, visible.
   // The walk limit is still at its reset value of 18 here.
   localparam sight_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Same tile on a blocked map is still visible.
      '{'{OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1}, KNOWN, 1'b1},
      // Every tile is blocked after reset.
      '{'{OP_QUERY, 0, 0, 0, 0, 0, 1, 0, 1}, KNOWN, 1'b0},
      // Target absent answers not visible, even for the same tile.
      '{'{OP_QUERY, 31, 31, 1, 31, 31, 31, 31, 0}, KNOWN, 1'b0},
      // Corner to corner is far longer than the limit.
      '{'{OP_QUERY, 0, 0, 0, 0, 0, 31, 31, 1}, KNOWN, 1'b0},
      '{'{OP_QUERY, 31, 31, 1, 31, 0, 0, 31, 1}, KNOWN, 1'b0},
      // Open a short row along the far edge and look along it.
      '{'{OP_WRITE, 31, 31, 1, 31, 31, 31, 31, 1}, PREDICTED, 1'b0},
      '{'{OP_WRITE, 30, 31, 1, 0, 0, 0, 0, 0}, PREDICTED, 1'b0},
      '{'{OP_WRITE, 29, 31, 1, 0, 0, 0, 0, 0}, PREDICTED, 1'b0},
      '{'{OP_QUERY, 31, 31, 1, 31, 31, 29, 31, 1}, PREDICTED, 1'b0},
      '{'{OP_QUERY, 0, 0, 0, 29, 31, 31, 31, 1}, PREDICTED, 1'b0},
      // Open the origin block and look across its diagonals.
      '{'{OP_WRITE, 0, 0, 1, 31, 31, 31, 31, 1}, PREDICTED, 1'b0},
      '{'{OP_WRITE, 1, 0, 1, 0, 0, 0, 0, 0}, PREDICTED, 1'b0},
      '{'{OP_WRITE, 0, 1, 1, 0, 0, 0, 0, 0}, PREDICTED, 1'b0},
      '{'{OP_WRITE, 1, 1, 1, 0, 0, 0, 0, 0}, PREDICTED, 1'b0},
      '{'{OP_QUERY, 0, 0, 0, 0, 0, 1, 1, 1}, PREDICTED, 1'b0},
      '{'{OP_QUERY, 31, 31, 1, 1, 1, 0, 0, 1}, PREDICTED, 1'b0},
      '{'{OP_QUERY, 0, 0, 0, 1, 0, 0, 1, 1}, PREDICTED, 1'b0},
      // Close the middle of the edge row; the walk along it must now fail.
      '{'{OP_WRITE, 30, 31, 0, 31, 31, 31, 31, 1}, PREDICTED, 1'b0},
      '{'{OP_QUERY, 0, 0, 0, 31, 31, 29, 31, 1}, PREDICTED, 1'b0},
      '{'{OP_QUERY, 0, 0, 0, 30, 31, 30, 31, 1}, KNOWN, 1'b1},
      // Extend the origin row and look along it.
      '{'{OP_WRITE, 2, 0, 1, 0, 0, 0, 0, 0}, PREDICTED, 1'b0},
      '{'{OP_WRITE, 3, 0, 1, 0, 0, 0, 0, 0}, PREDICTED, 1'b0},
      '{'{OP_WRITE, 4, 0, 1, 0, 0, 0, 0, 0}, PREDICTED, 1'b0},
      '{'{OP_QUERY, 0, 0, 0, 0, 0, 4, 0, 1}, PREDICTED, 1'b0},
      '{'{OP_QUERY, 0, 0, 0, 4, 1, 0, 0, 1}, PREDICTED, 1'b0}
   };

   localparam int RESET_PHASE_ITEMS = 100;
   localparam int PHASE_COUNT = 7;
   localparam phase_type PHASES [PHASE_COUNT] = '{
      '{0,   0,  0,  100},
      '{124, 76, 0,  110},
      '{127, 0,  76, 110},
      '{18,  13, 13, 110},
      '{37,  0,  0,  110},
      '{3,   76, 0,  100},
      '{124, 13, 13, 110}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [STEPS_W-1:0] csr_wr_data;

   glos_req_if req_if();
   glos_rsp_if rsp_if();

   grid_line_of_sight_check_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: the tile map, indexed [y][x], and the walk limit.
   logic               open_tiles [MAP_TILES][MAP_TILES];
   logic [STEPS_W-1:0] walk_limit;
   logic               visible_expected [$];

   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned failure_count;
   int unsigned quiet_cycles;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // One sub-cell walk: length check, then every cell entered must be open.
   function automatic logic walk_is_clear(int sx, int sy, int ex, int ey);
      int nx;
      int ny;
      int cx;
      int cy;
      int ix;
      int iy;
      nx = (sx > ex) ? sx - ex : ex - sx;
      ny = (sy > ey) ? sy - ey : ey - sy;
      cx = sx;
      cy = sy;
      ix = 0;
      iy = 0;
      if (nx + ny > int'(walk_limit)) return 1'b0;
      while (ix < nx || iy < ny) begin
         if ((1 + 2 * ix) * ny <= (1 + 2 * iy) * nx) begin
            cx = (ex > sx) ? cx + 1 : cx - 1;
            ix++;
         end else begin
            cy = (ey > sy) ? cy + 1 : cy - 1;
            iy++;
         end
         if (!open_tiles[cy >> 1][cx >> 1]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Visible when any of the four sub-cell offsets gives a clear walk.
   function automatic logic predict_visible(los_item_type q);
      int k;
      if (!q.target_present) return 1'b0;
      for (k = 0; k < 4; k++) begin
         if (walk_is_clear(2 * q.observer_x + (k & 1), 2 * q.observer_y + (k >> 1),
                           2 * q.target_x + (k & 1), 2 * q.target_y + (k >> 1)))
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // A coordinate up to twelve tiles away, kept on the map.
   function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 24)) - 12;
      if (v < 0) v = 0;
      if (v > MAP_TILES - 1) v = MAP_TILES - 1;
      return COORD_W'(v);
   endfunction

   // Present one request transaction, wait for acceptance, update the prediction.
   task automatic send_item(input los_item_type it, input logic known,
                            input logic known_visible);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.opcode         <= it.opcode;
      req_if.tile_x         <= it.tile_x;
      req_if.tile_y         <= it.tile_y;
      req_if.tile_open      <= it.tile_open;
      req_if.observer_x     <= it.observer_x;
      req_if.observer_y     <= it.observer_y;
      req_if.target_x       <= it.target_x;
      req_if.target_y       <= it.target_y;
      req_if.target_present <= it.target_present;
      do @(posedge clock); while (!req_if.ready);
      if (it.opcode == OP_WRITE)
         open_tiles[it.tile_y][it.tile_x] = it.tile_open;
      else if (known)
         visible_expected = {visible_expected, known_visible};
      else
         visible_expected = {visible_expected, predict_visible(it)};
   endtask

   // Bursts that open a rectangle of tiles and then look across it, mixed with noise.
   task automatic run_random(input int unsigned item_total);
      int unsigned  sent;
      int unsigned  w;
      int unsigned  h;
      int unsigned  ax;
      int unsigned  ay;
      int unsigned  x;
      int unsigned  y;
      int unsigned  k;
      int unsigned  queries;
      los_item_type it;
      sent = 0;
      while (sent < item_total) begin
         if ($urandom_range(0, 99) < 20) begin
            // Noise: every field random, including opcode and presence.
            it = los_item_type'(ITEM_W'({$urandom(), $urandom()}));
            send_item(it, PREDICTED, 1'b0);
            sent++;
         end else begin
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 3);
            if ($urandom_range(0, 1) == 1) begin
               x = w;
               w = h;
               h = x;
            end
            ax = $urandom_range(0, MAP_TILES - w);
            ay = $urandom_range(0, MAP_TILES - h);
            for (y = 0; y < h; y++) begin
               for (x = 0; x < w; x++) begin
                  it = los_item_type'(ITEM_W'({$urandom(), $urandom()}));
                  it.opcode    = OP_WRITE;
                  it.tile_x    = COORD_W'(ax + x);
                  it.tile_y    = COORD_W'(ay + y);
                  it.tile_open = ($urandom_range(0, 99) < 85);
                  send_item(it, PREDICTED, 1'b0);
                  sent++;
               end
            end
            queries = $urandom_range(2, 8);
            for (k = 0; k < queries; k++) begin
               it = los_item_type'(ITEM_W'({$urandom(), $urandom()}));
               it.opcode         = OP_QUERY;
               it.observer_x     = COORD_W'(ax + $urandom_range(0, w - 1));
               it.observer_y     = COORD_W'(ay + $urandom_range(0, h - 1));
               it.target_x       = COORD_W'(ax + $urandom_range(0, w - 1));
               it.target_y       = COORD_W'(ay + $urandom_range(0, h - 1));
               it.target_present = ($urandom_range(0, 99) < 95);
               if ($urandom_range(0, 99) < 25) begin
                  it.target_x = near_coord(it.observer_x);
                  it.target_y = near_coord(it.observer_y);
               end
               send_item(it, PREDICTED, 1'b0);
               sent++;
            end
         end
      end
   endtask

   // Let every expected result arrive, then give queued writes time to retire.
   task automatic wait_for_idle;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (visible_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The receiver stalls at random, per cycle.
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Check each response transaction against the oldest expectation; watch for a hang.
   always @(posedge clock) begin
      logic want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (visible_expected.size() == 0) begin
               $error("visible: expected none, actual %0b", rsp_if.visible);
               failure_count++;
            end else begin
               want = visible_expected.pop_front();
               if (rsp_if.visible !== want) begin
                  $error("visible: expected %0b, actual %0b", want, rsp_if.visible);
                  failure_count++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("grid_line_of_sight_check_core_test: FAIL");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed table, a random phase at the reset limit, then one random phase per setting.
   initial begin
      int unsigned r;
      int unsigned p;
      int unsigned x;
      int unsigned y;
      clock                 = 1'b0;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_if.valid          = 1'b0;
      req_if.opcode         = OP_WRITE;
      req_if.tile_x         = '0;
      req_if.tile_y         = '0;
      req_if.tile_open      = 1'b0;
      req_if.observer_x     = '0;
      req_if.observer_y     = '0;
      req_if.target_x       = '0;
      req_if.target_y       = '0;
      req_if.target_present = 1'b0;
      rsp_if.ready          = 1'b0;
      sender_idle_pct       = 0;
      receiver_stall_pct    = 0;
      failure_count         = 0;
      quiet_cycles          = 0;
      walk_limit            = MAX_STEPS_RESET;
      for (y = 0; y < MAP_TILES; y++)
         for (x = 0; x < MAP_TILES; x++)
            open_tiles[y][x] = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIRECTED_COUNT; r++)
         send_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].visible);
      run_random(RESET_PHASE_ITEMS);

      for (p = 0; p < PHASE_COUNT; p++) begin
         wait_for_idle();
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= PHASES[p].max_steps;
         walk_limit  = PHASES[p].max_steps;
         @(negedge clock);
         csr_wr_en <= 1'b0;
         sender_idle_pct    = PHASES[p].sender_idle;
         receiver_stall_pct = PHASES[p].receiver_stall;
         run_random(PHASES[p].items);
      end

      wait_for_idle();
      if (failure_count == 0)
         $display("grid_line_of_sight_check_core_test: PASS");
      else
         $display("grid_line_of_sight_check_core_test: FAIL");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/glos_pkg.sv
rtl/glos_channels.sv
rtl/glos_front.sv
rtl/glos_fifo.sv
rtl/glos_tile_map.sv
rtl/glos_walker.sv
rtl/grid_line_of_sight_check_core.sv
bench/grid_line_of_sight_check_core_test.sv
